[hw/rtl/base64_stream_encoder_core_assert.svh]
// Assertion macros shared by the Base64 stream encoder RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef BASE64_STREAM_ENCODER_CORE_ASSERT_SVH
`define BASE64_STREAM_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64E_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("b64e assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define B64E_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("b64e assertion failed");

`endif

[hw/rtl/b64e_pkg.sv]
// Shared types, constants and the sextet-to-ASCII mapping for the Base64 encoder.
// Depends on nothing; used by every module of the encoder.
package b64e_pkg;

    // Default depth of the job queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Byte used to complete a short group at the end of a message.
    localparam logic [7:0] FILL_BYTE = 8'h80;

    // Alphabet offsets and the two punctuation characters.
    localparam logic [6:0] OFS_UPPER = 7'd65;
    localparam logic [6:0] OFS_LOWER = 7'd71;
    localparam logic [6:0] OFS_DIGIT = 7'd4;
    localparam logic [6:0] CHAR_PLUS = 7'h2B;
    localparam logic [6:0] CHAR_SLASH = 7'h2F;

    typedef logic [5:0] t_sextet;

    // Position of the next byte within its three-byte group.
    typedef enum logic [1:0] {
        PH_BYTE0 = 2'd0,
        PH_BYTE1 = 2'd1,
        PH_BYTE2 = 2'd2
    } t_phase;

    // One accepted byte turned into one to four characters.
    typedef struct packed {
        t_sextet [3:0] sextet;  // sextet[0] is emitted first
        logic [1:0]    cnt_m1;  // number of characters minus one
        logic          last;    // final character closes the message
    } t_job;

    // Maps a six-bit value onto the Base64 alphabet.
    function automatic logic [6:0] sextet_to_ascii(input t_sextet v);
        logic [6:0] w;
        w = {1'b0, v};
        if (v <= 6'd25) begin
            return w + OFS_UPPER;
        end else if (v <= 6'd51) begin
            return w + OFS_LOWER;
        end else if (v <= 6'd61) begin
            return w - OFS_DIGIT;
        end else if (v == 6'd62) begin
            return CHAR_PLUS;
        end else begin
            return CHAR_SLASH;
        end
    endfunction

endpackage

[hw/rtl/base64_stream_encoder_core.sv]
// Path: a byte's job is queued, then its first character is loaded into the output register.
// Throughput: one character word per cycle from the serialiser while the receiver is ready;
// a byte gives one or two characters mid-group and up to four at the end of a message.
// The character serialiser sets the rate; the job queue lets input bytes arrive meanwhile.
// Reset: synchronous, active low; clears group phase, leftover bits, queue and output valid.
module base64_stream_encoder_core #(
    parameter int P_QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tlast,   // end_of_message
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [6:0] ascii_char, [7] zero fill
    output logic       o_m_tlast    // last_char
);

    b64e_pkg::t_job push_job, head_job;
    logic           push, pop, full, empty;

    // Byte classification and group tracking.
    b64e_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_tvalid),
        .o_tready (o_s_tready),
        .i_tdata  (i_s_tdata),
        .i_tlast  (i_s_tlast),
        .i_full   (full),
        .o_push   (push),
        .o_job    (push_job)
    );

    // Job queue.
    b64e_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_job)
    );

    // Character serialiser.
    b64e_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_head   (head_job),
        .o_pop    (pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast)
    );

endmodule

[hw/rtl/b64e_front.sv]
// Front end: accepts input words, tracks group phase and leftover bits, and
// builds a character job per byte. Depends on b64e_pkg.
module b64e_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tvalid,
    output logic            o_tready,
    input  logic [7:0]      i_tdata,   // [7:0] data_byte
    input  logic            i_tlast,   // end_of_message
    input  logic            i_full,
    output logic            o_push,
    output b64e_pkg::t_job  o_job
);

    b64e_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_left, n_left;
    logic             accept;
    logic [7:0]       fill;

    assign fill     = b64e_pkg::FILL_BYTE;
    assign o_tready = !i_full;
    assign accept   = i_tvalid && !i_full;
    assign o_push   = accept;

    // Job built from the current byte, the phase and the leftover bits.
    always_comb begin
        o_job        = '0;
        o_job.last   = i_tlast;
        unique case (r_phase)
            b64e_pkg::PH_BYTE1: begin
                o_job.sextet[0] = {r_left[1:0], i_tdata[7:4]};
                o_job.sextet[1] = {i_tdata[3:0], fill[7:6]};
                o_job.sextet[2] = fill[5:0];
                o_job.cnt_m1    = i_tlast ? 2'd2 : 2'd0;
            end
            b64e_pkg::PH_BYTE2: begin
                o_job.sextet[0] = {r_left, i_tdata[7:6]};
                o_job.sextet[1] = i_tdata[5:0];
                o_job.cnt_m1    = 2'd1;
            end
            default: begin
                o_job.sextet[0] = i_tdata[7:2];
                o_job.sextet[1] = {i_tdata[1:0], fill[7:4]};
                o_job.sextet[2] = {fill[3:0], fill[7:6]};
                o_job.sextet[3] = fill[5:0];
                o_job.cnt_m1    = i_tlast ? 2'd3 : 2'd0;
            end
        endcase
    end

    // Next phase and leftover bits; the end of a message starts a fresh group.
    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        if (accept) begin
            unique case (r_phase)
                b64e_pkg::PH_BYTE1: begin
                    n_phase = b64e_pkg::PH_BYTE2;
                    n_left  = i_tdata[3:0];
                end
                b64e_pkg::PH_BYTE2: begin
                    n_phase = b64e_pkg::PH_BYTE0;
                    n_left  = 4'd0;
                end
                default: begin
                    n_phase = b64e_pkg::PH_BYTE1;
                    n_left  = {2'b00, i_tdata[1:0]};
                end
            endcase
            if (i_tlast) begin
                n_phase = b64e_pkg::PH_BYTE0;
                n_left  = 4'd0;
            end
        end
    end

    // Group state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= b64e_pkg::PH_BYTE0;
            r_left  <= 4'd0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

endmodule

[hw/rtl/b64e_queue.sv]
// Short job queue between the front end and the character serialiser.
// Depends on b64e_pkg and the assertion macro header.
`include "base64_stream_encoder_core_assert.svh"

module b64e_queue #(
    parameter int P_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b64e_pkg::t_job  i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output b64e_pkg::t_job  o_head
);

    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(P_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(P_DEPTH);

    b64e_pkg::t_job    r_slot [P_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `B64E_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, o_full, !i_push)
    `B64E_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, o_empty, !i_pop)
    `B64E_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL_CNT)

endmodule

[hw/rtl/b64e_back.sv]
// Back end: serialises each job through an output register, one character word
// per cycle while the receiver is ready. Depends on b64e_pkg and the macro header.
`include "base64_stream_encoder_core_assert.svh"

module b64e_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  b64e_pkg::t_job  i_head,
    output logic            o_pop,
    output logic            o_tvalid,
    input  logic            i_tready,
    output logic [7:0]      o_tdata,   // [6:0] ascii_char, [7] zero
    output logic            o_tlast    // last_char
);

    logic [1:0] r_idx, n_idx;
    logic       r_valid;
    logic [6:0] r_char;
    logic       r_last;
    logic       load;
    logic       final_char;

    // A new character enters the output register when it is free or draining.
    assign load       = !i_empty && (!r_valid || i_tready);
    assign final_char = (r_idx == i_head.cnt_m1);
    assign o_pop      = load && final_char;

    always_comb begin
        n_idx = r_idx;
        if (load) begin
            n_idx = final_char ? 2'd0 : r_idx + 2'd1;
        end
    end

    // Control state of the serialiser and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output word payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= b64e_pkg::sextet_to_ascii(i_head.sextet[r_idx]);
            r_last <= i_head.last && final_char;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {1'b0, r_char};
    assign o_tlast  = r_last;

    `B64E_ASSERT_NOW(a_idx_in_job, i_clk, i_rst_n, !i_empty, r_idx <= i_head.cnt_m1)
    `B64E_ASSERT_NEXT(a_pop_restarts, i_clk, i_rst_n, o_pop, r_idx == 2'd0)
    `B64E_ASSERT_NEXT(a_hold_stable, i_clk, i_rst_n, o_tvalid && !i_tready, o_tvalid && $stable(o_tdata))

endmodule

[verif/base64_stream_encoder_core_test.sv]
// Self-checking testbench for base64_stream_encoder_core: directed and random messages in, characters checked.
// Depends on b64e_pkg and the encoder RTL; a scoreboard class holds its own encoder state.
`timescale 1ns / 1ps

module base64_stream_encoder_core_test;

    localparam int ITEM_TARGET  = 350;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam string B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // Keeps its own copy of the group position and carried bits, and the characters still owed.
    class char_scoreboard;
        typedef struct packed {
            logic [6:0] ascii;
            logic       last;
        } t_char;

        t_char             owed_q[$];
        b64e_pkg::t_phase  phase;
        logic [3:0]        carry;
        int unsigned       n_fail;
        int unsigned       n_bytes;
        int unsigned       n_msgs;
        int unsigned       n_chars;

        function new();
            phase   = b64e_pkg::PH_BYTE0;
            carry   = 4'd0;
            n_fail  = 0;
            n_bytes = 0;
            n_msgs  = 0;
            n_chars = 0;
        endfunction

        function void push_sextet(input logic [5:0] v);
            t_char c;
            byte   ch;
            ch = B64_ALPHABET[v];
            c.ascii = ch[6:0];
            c.last  = 1'b0;
            owed_q = {owed_q, c};
        endfunction

        // One byte through the three-byte group, giving one or two characters.
        function void absorb(input logic [7:0] b);
            case (phase)
                b64e_pkg::PH_BYTE1: begin
                    push_sextet({carry[1:0], b[7:4]});
                    carry = b[3:0];
                    phase = b64e_pkg::PH_BYTE2;
                end
                b64e_pkg::PH_BYTE2: begin
                    push_sextet({carry, b[7:6]});
                    push_sextet(b[5:0]);
                    carry = 4'd0;
                    phase = b64e_pkg::PH_BYTE0;
                end
                default: begin
                    push_sextet(b[7:2]);
                    carry = {2'b00, b[1:0]};
                    phase = b64e_pkg::PH_BYTE1;
                end
            endcase
        endfunction

        // Notes an accepted input word; at the end of a message the short group is filled.
        function void note_byte(input logic [7:0] b, input logic eom);
            absorb(b);
            n_bytes++;
            if (eom) begin
                while (phase != b64e_pkg::PH_BYTE0) begin
                    absorb(b64e_pkg::FILL_BYTE);
                end
                carry = 4'd0;
                owed_q[owed_q.size() - 1].last = 1'b1;
                n_msgs++;
            end
        endfunction

        // Compares one output word with the oldest owed character.
        function void check_char(input logic [7:0] data, input logic last);
            t_char c;
            if (owed_q.size() == 0) begin
                $error("unexpected character word: tdata=%h tlast=%b", data, last);
                n_fail++;
                return;
            end
            c = owed_q.pop_front();
            n_chars++;
            if (data[6:0] !== c.ascii) begin
                $error("ascii_char: expected %h, got %h", c.ascii, data[6:0]);
                n_fail++;
            end
            if (data[7] !== 1'b0) begin
                $error("tdata fill bit: expected 0, got %b", data[7]);
                n_fail++;
            end
            if (last !== c.last) begin
                $error("last_char: expected %b, got %b", c.last, last);
                n_fail++;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic       i_clk   = 1'b0;
    logic       rst_n   = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_data  = 8'd0;
    logic       s_last  = 1'b0;
    logic       m_ready = 1'b0;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;
    logic       o_m_tlast;

    char_scoreboard sb;
    bit          hold_req = 1'b0;
    bit          no_idle  = 1'b0;
    int unsigned n_holds  = 0;
    int unsigned cycles   = 0;

    // Directed words as {end_of_message, data_byte}: extremes, '+', '/', digits, every end phase.
    logic [8:0] dir_items [22] = '{
        9'h100, 9'h1FF,
        9'h0FB, 9'h0EF, 9'h1BE,
        9'h0FF, 9'h0FF, 9'h1FF,
        9'h0D3, 9'h04D, 9'h134,
        9'h012, 9'h134,
        9'h000, 9'h07F, 9'h080, 9'h101,
        9'h0A5, 9'h05A, 9'h0C3, 9'h03C, 9'h169
    };

    base64_stream_encoder_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),      // [7:0] data_byte
        .i_s_tlast  (s_last),      // end_of_message
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata),   // [6:0] ascii_char, [7] zero fill
        .o_m_tlast  (o_m_tlast)    // last_char
    );

    always #1 i_clk = ~i_clk;

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 8'h00;
        end else if (r == 1) begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Offers one word and returns at the edge that takes it, after an optional gap.
    task automatic send_word(input logic [7:0] b, input logic eom);
        int gap;
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= eom;
        do begin
            @(negedge i_clk);
        end while (!o_s_tready);
        sb.note_byte(b, eom);
        @(posedge i_clk);
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stops sending until every owed character has come out, then lets the pipeline settle.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Receiver ready: random stalls, a long hold-off on request, none during steady stretches.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                n_holds++;
            end else if (no_idle || stall_left == 0) begin
                m_ready <= 1'b1;
                stall_left = no_idle ? 0 : pick_gap();
            end else begin
                m_ready <= 1'b0;
                stall_left--;
            end
        end
    end

    // Output words are sampled mid-cycle, where they hold what the next edge transfers.
    initial begin
        forever begin
            @(negedge i_clk);
            if (rst_n && o_m_tvalid && m_ready) begin
                sb.check_char(o_m_tdata, o_m_tlast);
            end
        end
    end

    // Stimulus: directed messages, then random messages with pressure phases.
    initial begin
        int n_msg;
        int len;
        sb = new();
        n_msg = 0;
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_items[k]) begin
            send_word(dir_items[k][7:0], dir_items[k][8]);
        end
        wait_drained();

        while (sb.n_bytes < ITEM_TARGET) begin
            if (n_msg == 4) begin
                hold_req = 1'b1;
            end
            no_idle = (n_msg >= 12 && n_msg < 20);
            if (n_msg == 30 || n_msg == 60) begin
                wait_drained();
            end
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            for (int j = 0; j < len; j++) begin
                send_word(pick_byte(), j == len - 1);
            end
            n_msg++;
        end
        wait_drained();

        $display("Run covered %0d bytes in %0d messages and %0d characters checked,",
                 sb.n_bytes, sb.n_msgs, sb.n_chars);
        $display("with random gaps on both sides and %0d long receiver hold-off(s).", n_holds);
        if (sb.n_fail == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
